@@ sv/jdv_pkg.sv @@
// jdv_pkg: shared widths, configuration, command and status types
// for the joystick deadzone velocity block; no dependencies
package jdv_pkg;

   // field and datapath widths
   localparam int MV_W    = 12;  // millivolt sample
   localparam int OFF_W   = 14;  // offset from rest, with room for the deadzone compare
   localparam int EFF_W   = 13;  // deflection beyond the deadzone
   localparam int GAIN_W  = 16;  // gain multiplier and divisor
   localparam int ACC_W   = 30;  // product plus carry, signed
   localparam int MAG_W   = 29;  // magnitude into the divider
   localparam int DELTA_W = 29;  // reported motion
   localparam int CARRY_W = 17;  // signed remainder carried between samples
   localparam int SUM_W   = 16;  // calibration sum

   // configuration registers as seen by the datapath
   typedef struct packed {
      logic [MV_W-1:0]   centre_level;
      logic [MV_W-1:0]   deadzone;
      logic [GAIN_W-1:0] gain_mul;
      logic [GAIN_W-1:0] gain_div;
      logic              flip_x;
      logic              flip_y;
      logic              exchange;
   } cfg_type;

   // datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,        // capture the sample pair
      OP_CAL_ACC,     // add the pair to the calibration sums
      OP_CAL_DIV,     // start dividing one calibration sum
      OP_CAL_STORE,   // store the mean as one axis rest level
      OP_OFFSET,      // offset from rest, deadzone test
      OP_MUL,         // deflection times gain
      OP_ACC,         // add carry, split sign and magnitude
      OP_DIV,         // start dividing by the gain divisor
      OP_AXIS_STORE,  // keep quotient and new carry
      OP_AXIS_ZERO,   // axis in deadzone: zero delta, clear carry
      OP_SHOW         // load the result register
   } op_type;

   typedef enum logic {
      AXIS_X,
      AXIS_Y
   } axis_type;

   typedef struct packed {
      op_type   op;
      axis_type axis;
   } cmd_type;

   typedef struct packed {
      logic cal_active;    // centre unset and calibration pairs still due
      logic samples_zero;  // calibration count has run out
      logic dead;          // last offset fell inside the deadzone
      logic div_busy;      // divider iterating
      logic nonzero;       // at least one delta is nonzero
   } stat_type;

endpackage

@@ sv/joystick_deadzone_velocity.sv @@
// Joystick deadzone velocity mapper. Each input beat carries one X/Y pair of
// millivolt samples; each output beat carries the X/Y motion for that pair, and
// pairs whose motion is zero on both axes give no output beat. While
// centre_level is zero the first CAL_SAMPLES pairs only calibrate the rest
// levels and give no output. The radix-2 divider, one quotient bit per cycle
// over 29 bits, is shared in turn by the two axes and the calibration mean.
// A finished beat waits in the output register while the next pair is taken
// in. Registers (32-bit APB, byte address 4*i): 0 centre_level, 1 deadzone,
// 2 gain_multiplier, 3 gain_divisor (0 acts as 1), 4 flip_x, 5 flip_y,
// 6 exchange_axes. Write configuration only while no pair is in flight.
module joystick_deadzone_velocity #(
   parameter int CAL_SAMPLES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // sample channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [jdv_pkg::MV_W-1:0]            req_x_mv,
   input  logic [jdv_pkg::MV_W-1:0]            req_y_mv,
   // motion channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [jdv_pkg::DELTA_W-1:0]  rsp_dx,
   output logic signed [jdv_pkg::DELTA_W-1:0]  rsp_dy,
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [4:0]                          csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   localparam logic [2:0] RegCentre   = 3'd0;
   localparam logic [2:0] RegDeadzone = 3'd1;
   localparam logic [2:0] RegGainMul  = 3'd2;
   localparam logic [2:0] RegGainDiv  = 3'd3;
   localparam logic [2:0] RegFlipX    = 3'd4;
   localparam logic [2:0] RegFlipY    = 3'd5;
   localparam logic [2:0] RegExchange = 3'd6;

   localparam int MvW   = jdv_pkg::MV_W;
   localparam int GainW = jdv_pkg::GAIN_W;

   jdv_pkg::cfg_type   cfg_ff, cfg_in;
   jdv_pkg::cmd_type   cmd;
   jdv_pkg::stat_type  stat;
   logic               wr_en;
   logic [2:0]         reg_index;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_index  = csr_paddr[4:2];

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            RegCentre:   cfg_in.centre_level = csr_pwdata[MvW-1:0];
            RegDeadzone: cfg_in.deadzone     = csr_pwdata[MvW-1:0];
            RegGainMul:  cfg_in.gain_mul     = csr_pwdata[GainW-1:0];
            RegGainDiv:  cfg_in.gain_div     = csr_pwdata[GainW-1:0];
            RegFlipX:    cfg_in.flip_x       = csr_pwdata[0];
            RegFlipY:    cfg_in.flip_y       = csr_pwdata[0];
            RegExchange: cfg_in.exchange     = csr_pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.centre_level <= '0;
         cfg_ff.deadzone     <= '0;
         cfg_ff.gain_mul     <= GainW'(1);
         cfg_ff.gain_div     <= GainW'(1);
         cfg_ff.flip_x       <= 1'b0;
         cfg_ff.flip_y       <= 1'b0;
         cfg_ff.exchange     <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // register readback
   always_comb begin
      csr_prdata = '0;
      case (reg_index)
         RegCentre:   csr_prdata = 32'(cfg_ff.centre_level);
         RegDeadzone: csr_prdata = 32'(cfg_ff.deadzone);
         RegGainMul:  csr_prdata = 32'(cfg_ff.gain_mul);
         RegGainDiv:  csr_prdata = 32'(cfg_ff.gain_div);
         RegFlipX:    csr_prdata = 32'(cfg_ff.flip_x);
         RegFlipY:    csr_prdata = 32'(cfg_ff.flip_y);
         RegExchange: csr_prdata = 32'(cfg_ff.exchange);
         default:     csr_prdata = '0;
      endcase
   end

   jdv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   jdv_dpath #(
      .CAL_SAMPLES (CAL_SAMPLES)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .cmd      (cmd),
      .stat     (stat),
      .req_x_mv (req_x_mv),
      .req_y_mv (req_y_mv),
      .rsp_dx   (rsp_dx),
      .rsp_dy   (rsp_dy)
   );

endmodule

@@ sv/jdv_div.sv @@
// jdv_div: radix-2 restoring divider, one quotient bit per cycle
// uses jdv_pkg for widths
module jdv_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [jdv_pkg::MAG_W-1:0]     dividend,
   input  logic [jdv_pkg::GAIN_W-1:0]    divisor,
   output logic                          busy,
   output logic [jdv_pkg::MAG_W-1:0]     quotient,
   output logic [jdv_pkg::GAIN_W-1:0]    remainder
);

   localparam int MagW  = jdv_pkg::MAG_W;
   localparam int GainW = jdv_pkg::GAIN_W;
   localparam int CntW  = $clog2(MagW);

   logic             busy_ff, busy_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic [MagW-1:0]  quo_ff, quo_in;
   logic [GainW-1:0] rem_ff, rem_in;
   logic [GainW-1:0] dvs_ff, dvs_in;
   logic [GainW:0]   shifted;
   logic [GainW:0]   trial;

   // one shift and trial subtract per cycle
   always_comb begin
      shifted = {rem_ff, quo_ff[MagW-1]};
      trial   = shifted - {1'b0, dvs_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CntW'(MagW - 1);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = trial[GainW-1:0];
            quo_in = {quo_ff[MagW-2:0], 1'b1};
         end else begin
            rem_in = shifted[GainW-1:0];
            quo_in = {quo_ff[MagW-2:0], 1'b0};
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   // operand and iteration registers
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

@@ sv/jdv_dpath.sv @@
// jdv_dpath: sample, calibration, deadzone, gain and carry datapath
// uses jdv_pkg types and instantiates jdv_div
module jdv_dpath #(
   parameter int CAL_SAMPLES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  jdv_pkg::cfg_type                    cfg,
   input  jdv_pkg::cmd_type                    cmd,
   output jdv_pkg::stat_type                   stat,
   input  logic [jdv_pkg::MV_W-1:0]            req_x_mv,
   input  logic [jdv_pkg::MV_W-1:0]            req_y_mv,
   output logic signed [jdv_pkg::DELTA_W-1:0]  rsp_dx,
   output logic signed [jdv_pkg::DELTA_W-1:0]  rsp_dy
);

   localparam int MvW    = jdv_pkg::MV_W;
   localparam int OffW   = jdv_pkg::OFF_W;
   localparam int EffW   = jdv_pkg::EFF_W;
   localparam int GainW  = jdv_pkg::GAIN_W;
   localparam int AccW   = jdv_pkg::ACC_W;
   localparam int MagW   = jdv_pkg::MAG_W;
   localparam int DeltaW = jdv_pkg::DELTA_W;
   localparam int CarryW = jdv_pkg::CARRY_W;
   localparam int SumW   = jdv_pkg::SUM_W;
   localparam int CntW   = $clog2(CAL_SAMPLES + 1);

   // persistent state
   logic [MvW-1:0]            rest_x_ff, rest_x_in, rest_y_ff, rest_y_in;
   logic signed [CarryW-1:0]  carry_x_ff, carry_x_in, carry_y_ff, carry_y_in;
   logic [CntW-1:0]           samples_ff, samples_in;
   logic [SumW-1:0]           sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;

   // per-item working registers
   logic [MvW-1:0]            xm_ff, xm_in, ym_ff, ym_in;
   logic signed [EffW-1:0]    eff_ff, eff_in;
   logic                      dead_ff, dead_in;
   logic signed [AccW-1:0]    prod_ff, prod_in;
   logic                      sign_ff, sign_in;
   logic [MagW-1:0]           mag_ff, mag_in;
   logic signed [DeltaW-1:0]  qx_ff, qx_in, qy_ff, qy_in;
   logic signed [DeltaW-1:0]  dx_ff, dx_in, dy_ff, dy_in;

   // combinational terms
   logic                      on_y;
   logic [MvW-1:0]            mv_sel, rest_sel;
   logic signed [CarryW-1:0]  carry_sel;
   logic [SumW-1:0]           sum_sel;
   logic signed [OffW-1:0]    off, dzs, diff_hi, diff_lo;
   logic                      above, below;
   logic signed [AccW-1:0]    eff_ext, gain_ext, prod_w, carry_ext, acc_w, acc_neg;
   logic                      div_start, cal_div;
   logic [MagW-1:0]           dividend;
   logic [GainW-1:0]          divisor, gain_div_eff;
   logic                      div_busy;
   logic [MagW-1:0]           quot, quot_neg;
   logic [GainW-1:0]          rem;
   logic [CarryW-1:0]         rem_ext, rem_neg;
   logic signed [DeltaW-1:0]  sx, sy;
   logic [DeltaW-1:0]         sx_neg, sy_neg;

   // axis selection and offset from rest
   always_comb begin
      on_y      = (cmd.axis == jdv_pkg::AXIS_Y);
      mv_sel    = on_y ? ym_ff : xm_ff;
      carry_sel = on_y ? carry_y_ff : carry_x_ff;
      sum_sel   = on_y ? sum_y_ff : sum_x_ff;
      if (cfg.centre_level != '0) begin
         rest_sel = cfg.centre_level;
      end else begin
         rest_sel = on_y ? rest_y_ff : rest_x_ff;
      end
      off     = $signed({2'b00, mv_sel}) - $signed({2'b00, rest_sel});
      dzs     = $signed({2'b00, cfg.deadzone});
      diff_hi = off - dzs;
      diff_lo = off + dzs;
      above   = (off > dzs);
      below   = (off < -dzs);
   end

   // gain product and carry add, magnitude for the divider
   always_comb begin
      eff_ext   = AccW'(eff_ff);
      gain_ext  = $signed({{(AccW - GainW){1'b0}}, cfg.gain_mul});
      prod_w    = eff_ext * gain_ext;
      carry_ext = AccW'(carry_sel);
      acc_w     = prod_ff + carry_ext;
      acc_neg   = -acc_w;
   end

   // shared divider: calibration mean or gain division
   assign cal_div      = (cmd.op == jdv_pkg::OP_CAL_DIV);
   assign div_start    = cal_div || (cmd.op == jdv_pkg::OP_DIV);
   assign gain_div_eff = (cfg.gain_div == '0) ? GainW'(1) : cfg.gain_div;
   assign dividend     = cal_div ? MagW'(sum_sel) : mag_ff;
   assign divisor      = cal_div ? GainW'(CAL_SAMPLES) : gain_div_eff;

   jdv_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (dividend),
      .divisor   (divisor),
      .busy      (div_busy),
      .quotient  (quot),
      .remainder (rem)
   );

   // signed quotient and carry, swap and flip
   always_comb begin
      quot_neg = -quot;
      rem_ext  = {1'b0, rem};
      rem_neg  = -rem_ext;
      sx       = cfg.exchange ? qy_ff : qx_ff;
      sy       = cfg.exchange ? qx_ff : qy_ff;
      sx_neg   = -sx;
      sy_neg   = -sy;
   end

   // operation decode
   always_comb begin
      rest_x_in  = rest_x_ff;
      rest_y_in  = rest_y_ff;
      carry_x_in = carry_x_ff;
      carry_y_in = carry_y_ff;
      samples_in = samples_ff;
      sum_x_in   = sum_x_ff;
      sum_y_in   = sum_y_ff;
      xm_in      = xm_ff;
      ym_in      = ym_ff;
      eff_in     = eff_ff;
      dead_in    = dead_ff;
      prod_in    = prod_ff;
      sign_in    = sign_ff;
      mag_in     = mag_ff;
      qx_in      = qx_ff;
      qy_in      = qy_ff;
      dx_in      = dx_ff;
      dy_in      = dy_ff;
      case (cmd.op)
         jdv_pkg::OP_LOAD: begin
            xm_in = req_x_mv;
            ym_in = req_y_mv;
         end
         jdv_pkg::OP_CAL_ACC: begin
            sum_x_in   = sum_x_ff + SumW'(xm_ff);
            sum_y_in   = sum_y_ff + SumW'(ym_ff);
            samples_in = samples_ff - 1'b1;
         end
         jdv_pkg::OP_CAL_STORE: begin
            if (on_y) begin
               rest_y_in = quot[MvW-1:0];
            end else begin
               rest_x_in = quot[MvW-1:0];
            end
         end
         jdv_pkg::OP_OFFSET: begin
            eff_in  = above ? diff_hi[EffW-1:0] : diff_lo[EffW-1:0];
            dead_in = !above && !below;
         end
         jdv_pkg::OP_MUL: begin
            prod_in = prod_w;
         end
         jdv_pkg::OP_ACC: begin
            sign_in = acc_w[AccW-1];
            mag_in  = acc_w[AccW-1] ? acc_neg[MagW-1:0] : acc_w[MagW-1:0];
         end
         jdv_pkg::OP_AXIS_STORE: begin
            if (on_y) begin
               qy_in      = sign_ff ? quot_neg : quot;
               carry_y_in = sign_ff ? rem_neg : rem_ext;
            end else begin
               qx_in      = sign_ff ? quot_neg : quot;
               carry_x_in = sign_ff ? rem_neg : rem_ext;
            end
         end
         jdv_pkg::OP_AXIS_ZERO: begin
            if (on_y) begin
               qy_in      = '0;
               carry_y_in = '0;
            end else begin
               qx_in      = '0;
               carry_x_in = '0;
            end
         end
         jdv_pkg::OP_SHOW: begin
            dx_in = cfg.flip_x ? sx_neg : sx;
            dy_in = cfg.flip_y ? sy_neg : sy;
         end
         default: begin
         end
      endcase
   end

   // state that reset puts back to the uncalibrated start
   always_ff @(posedge clock) begin
      if (reset) begin
         rest_x_ff  <= '0;
         rest_y_ff  <= '0;
         carry_x_ff <= '0;
         carry_y_ff <= '0;
         samples_ff <= CntW'(CAL_SAMPLES);
         sum_x_ff   <= '0;
         sum_y_ff   <= '0;
      end else begin
         rest_x_ff  <= rest_x_in;
         rest_y_ff  <= rest_y_in;
         carry_x_ff <= carry_x_in;
         carry_y_ff <= carry_y_in;
         samples_ff <= samples_in;
         sum_x_ff   <= sum_x_in;
         sum_y_ff   <= sum_y_in;
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      xm_ff   <= xm_in;
      ym_ff   <= ym_in;
      eff_ff  <= eff_in;
      dead_ff <= dead_in;
      prod_ff <= prod_in;
      sign_ff <= sign_in;
      mag_ff  <= mag_in;
      qx_ff   <= qx_in;
      qy_ff   <= qy_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
   end

   // status to the controller
   always_comb begin
      stat.cal_active   = (cfg.centre_level == '0) && (samples_ff != '0);
      stat.samples_zero = (samples_ff == '0);
      stat.dead         = dead_ff;
      stat.div_busy     = div_busy;
      stat.nonzero      = (qx_ff != '0) || (qy_ff != '0);
   end

   assign rsp_dx = dx_ff;
   assign rsp_dy = dy_ff;

endmodule

@@ sv/jdv_ctrl.sv @@
// jdv_ctrl: sequencer for calibration and the two axis computations,
// owns the input and result handshakes; uses jdv_pkg command and status types
module jdv_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  jdv_pkg::stat_type  stat,
   output jdv_pkg::cmd_type   cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_CAL_CHK,
      ST_CAL_DIV,
      ST_CAL_WAIT,
      ST_OFFSET,
      ST_MUL,
      ST_ACC,
      ST_DIV,
      ST_WAIT,
      ST_FINISH
   } state_type;

   state_type          state_ff, state_in;
   jdv_pkg::axis_type  axis_ff, axis_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               show;

   // next state and command decode
   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      show     = 1'b0;
      cmd.op   = jdv_pkg::OP_NONE;
      cmd.axis = axis_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = jdv_pkg::OP_LOAD;
               axis_in  = jdv_pkg::AXIS_X;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.cal_active) begin
               cmd.op   = jdv_pkg::OP_CAL_ACC;
               state_in = ST_CAL_CHK;
            end else begin
               state_in = ST_OFFSET;
            end
         end
         ST_CAL_CHK: begin
            state_in = stat.samples_zero ? ST_CAL_DIV : ST_IDLE;
         end
         ST_CAL_DIV: begin
            cmd.op   = jdv_pkg::OP_CAL_DIV;
            state_in = ST_CAL_WAIT;
         end
         ST_CAL_WAIT: begin
            if (!stat.div_busy) begin
               cmd.op = jdv_pkg::OP_CAL_STORE;
               if (axis_ff == jdv_pkg::AXIS_X) begin
                  axis_in  = jdv_pkg::AXIS_Y;
                  state_in = ST_CAL_DIV;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_OFFSET: begin
            cmd.op   = jdv_pkg::OP_OFFSET;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (stat.dead) begin
               cmd.op = jdv_pkg::OP_AXIS_ZERO;
               if (axis_ff == jdv_pkg::AXIS_X) begin
                  axis_in  = jdv_pkg::AXIS_Y;
                  state_in = ST_OFFSET;
               end else begin
                  state_in = ST_FINISH;
               end
            end else begin
               cmd.op   = jdv_pkg::OP_MUL;
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            cmd.op   = jdv_pkg::OP_ACC;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.op   = jdv_pkg::OP_DIV;
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (!stat.div_busy) begin
               cmd.op = jdv_pkg::OP_AXIS_STORE;
               if (axis_ff == jdv_pkg::AXIS_X) begin
                  axis_in  = jdv_pkg::AXIS_Y;
                  state_in = ST_OFFSET;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            // both deltas zero: drop the beat
            if (!stat.nonzero) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               cmd.op   = jdv_pkg::OP_SHOW;
               show     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = show || (rsp_valid_ff && !rsp_ready);
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= jdv_pkg::AXIS_X;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
